>>> rtl/adpcm_decode_filter_upsampler_macros.svh
// Assertion macros for the ADPCM decode, filter and resample block.
// Used by the top level; depends on signals named clk and rst_n in scope.
`ifndef ADPCM_DECODE_FILTER_UPSAMPLER_MACROS_SVH
`define ADPCM_DECODE_FILTER_UPSAMPLER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ADFU_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ADFU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/adfu_pkg.sv
// Shared types, constants and tables for the ADPCM decode, filter and resample block.
// No dependencies; imported by every module of the block.
package adfu_pkg;

  localparam int CHANNELS      = 2;
  localparam int FRACTION_BITS = 18;
  localparam int MAX_EMIT      = 64;

  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RATE_W   = 21;
  localparam int PHASE_W  = (FRACTION_BITS + 3 > RATE_W) ? FRACTION_BITS + 3 : RATE_W;
  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 7;
  localparam int CODE_W   = 4;
  localparam int FILT_W   = 18;
  localparam int CNT_W    = $clog2(MAX_EMIT);

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  localparam logic [INDEX_W-1:0] INDEX_MAX  = 7'd88;
  localparam logic [RATE_W-1:0]  RATE_RESET = 21'd262144;
  localparam logic [RATE_W-1:0]  RATE_MIN   = 21'd4096;
  localparam logic [RATE_W-1:0]  RATE_MAX   = 21'd1048576;
  localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1) << FRACTION_BITS;
  localparam logic [PHASE_W-1:0] PHASE_TWO  = PHASE_W'(2) << FRACTION_BITS;
  localparam logic [CNT_W-1:0]   CNT_LAST   = CNT_W'(MAX_EMIT - 1);

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_CODE  = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic        [INDEX_W-1:0]  index;
    logic signed [SAMPLE_W-1:0] prev;
    logic signed [FILT_W-1:0]   older;
    logic signed [FILT_W-1:0]   newer;
    logic        [PHASE_W-1:0]  phase;
  } entry_t;

  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] start_sample;
    logic        [INDEX_W-1:0]  start_index;
    logic        [CODE_W-1:0]   code;
  } item_t;

  typedef struct packed {
    logic drop;
    logic error;
  } dec_flags_t;

  localparam entry_t ENTRY_RESET = '{
    sample: '0, index: '0, prev: '0, older: '0, newer: '0, phase: PHASE_TWO
  };

  localparam logic [14:0] STEP_TABLE [89] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41,
    15'd45, 15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97,
    15'd107, 15'd118, 15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209,
    15'd230, 15'd253, 15'd279, 15'd307, 15'd337, 15'd371, 15'd408, 15'd449,
    15'd494, 15'd544, 15'd598, 15'd658, 15'd724, 15'd796, 15'd876, 15'd963,
    15'd1060, 15'd1166, 15'd1282, 15'd1411, 15'd1552, 15'd1707, 15'd1878,
    15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024, 15'd3327, 15'd3660,
    15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484, 15'd7132,
    15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899,
    15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    logic signed [4:0] adj;
    case (mag)
      3'd4:    adj = 5'sd2;
      3'd5:    adj = 5'sd4;
      3'd6:    adj = 5'sd6;
      3'd7:    adj = 5'sd8;
      default: adj = -5'sd1;
    endcase
    return adj;
  endfunction

endpackage

>>> rtl/adfu_decode.sv
// One decode and filter step on a channel's state entry for a start or code item.
// Depends on adfu_pkg for the entry and item types and the step table.
module adfu_decode (
  input  adfu_pkg::entry_t     cur,
  input  adfu_pkg::item_t      item,
  output adfu_pkg::entry_t     nxt,
  output adfu_pkg::dec_flags_t flags
);
  import adfu_pkg::*;

  logic        [INDEX_W-1:0]  start_idx;
  logic        [INDEX_W-1:0]  code_idx;
  logic        [2:0]          mag;
  logic        [14:0]         step;
  logic        [16:0]         delta;
  logic signed [17:0]         sum;
  logic signed [SAMPLE_W-1:0] dec_sample;
  logic signed [7:0]          idx_sum;
  logic        [INDEX_W-1:0]  dec_idx;
  logic signed [SAMPLE_W-1:0] x;
  logic signed [FILT_W-1:0]   x_ext;
  logic signed [FILT_W-1:0]   p_ext;
  logic signed [FILT_W-1:0]   filt;

  always_comb begin
    start_idx = (item.start_index > INDEX_MAX) ? INDEX_MAX : item.start_index;
    code_idx  = (cur.index > INDEX_MAX) ? INDEX_MAX : cur.index;
    mag       = item.code[2:0];
    step      = STEP_TABLE[code_idx];
    delta     = 17'(step >> 3);
    if (mag[2]) delta = delta + 17'(step);
    if (mag[1]) delta = delta + 17'(step >> 1);
    if (mag[0]) delta = delta + 17'(step >> 2);
    if (item.code[3]) begin
      sum = 18'(cur.sample) - $signed({1'b0, delta});
    end else begin
      sum = 18'(cur.sample) + $signed({1'b0, delta});
    end
    if (sum < -18'sd32768) begin
      dec_sample = -16'sd32768;
    end else if (sum > 18'sd32767) begin
      dec_sample = 16'sd32767;
    end else begin
      dec_sample = sum[SAMPLE_W-1:0];
    end
    idx_sum = $signed({1'b0, code_idx}) + 8'(index_adjust(mag));
    if (idx_sum < 8'sd0) begin
      dec_idx = '0;
    end else if (idx_sum > $signed({1'b0, INDEX_MAX})) begin
      dec_idx = INDEX_MAX;
    end else begin
      dec_idx = idx_sum[INDEX_W-1:0];
    end

    x     = (item.func == FUNC_CODE) ? dec_sample : item.start_sample;
    x_ext = FILT_W'(x);
    p_ext = FILT_W'(cur.prev);
    filt  = p_ext + (p_ext >>> 1) - (x_ext >>> 1);

    nxt   = cur;
    flags = '0;
    if (cur.phase < PHASE_ONE) begin
      flags.drop  = (item.func == FUNC_CODE);
      flags.error = (item.func == FUNC_START);
    end else begin
      nxt.sample = x;
      nxt.index  = (item.func == FUNC_CODE) ? dec_idx : start_idx;
      nxt.prev   = x;
      nxt.phase  = cur.phase - PHASE_ONE;
      if (item.func == FUNC_START && cur.phase >= PHASE_TWO) begin
        nxt.older = x_ext;
        nxt.newer = x_ext;
      end else begin
        nxt.older = cur.newer;
        nxt.newer = filt;
      end
    end
  end

endmodule

>>> rtl/adpcm_decode_filter_upsampler.sv
// An item is taken only in the idle state; its channel entry is read from the state memory on
// the accepting edge, decoded and filtered in the next cycle, and then its interpolated words
// leave at one per cycle while the output is not stalled, at most MAX_EMIT of them; a dropped
// item yields no word, and no new item is taken until the block is back in the idle state.
// Synchronous active-low reset sets rate_r to 1.0 and marks every channel entry unwritten,
// so it reads as the reset state; a configuration write also marks every entry unwritten.
`include "adpcm_decode_filter_upsampler_macros.svh"

module adpcm_decode_filter_upsampler (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // channel, start_sample, start_index, code
  input  logic [adfu_pkg::IN_DATA_W-1:0]   in_tdata,
  // func
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // channel_out, sample_byte
  output logic [adfu_pkg::OUT_DATA_W-1:0]  out_tdata,
  // error
  output logic                             out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [adfu_pkg::RATE_W-1:0]      cfg_data
);
  import adfu_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_DECODE, ST_ERROR, ST_EMIT} fsm_t;

  fsm_t                    state_r, state_nxt;
  item_t                   item_r, item_nxt;
  logic                    ch_r, ch_nxt;
  entry_t                  work_r, work_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [RATE_W-1:0]       rate_r, rate_nxt;
  logic [CHANNELS-1:0]     valid_r, valid_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_err_r, out_err_nxt;

  entry_t                  mem [CHANNELS];
  entry_t                  rd_data_r;
  logic                    rd_valid_r;
  logic                    mem_we;
  entry_t                  mem_wdata;

  logic                    in_accept;
  logic                    in_ch;
  logic                    ch_ok;
  logic [CH_AW-1:0]        in_addr;
  logic [CH_AW-1:0]        wr_addr;
  logic                    cfg_write;
  entry_t                  cur_entry;
  entry_t                  dec_entry;
  dec_flags_t              dec_flags;
  logic                    out_free;
  logic                    emit_go;
  logic                    emit_last;
  logic signed [FILT_W:0]  diff;
  logic signed [8:0]       frac;
  logic signed [27:0]      prod;
  logic signed [20:0]      smp;
  logic [PHASE_W-1:0]      phase_sum;
  logic [RATE_W-1:0]       rate_sat;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign in_ch      = in_tdata[0];
  assign ch_ok      = (32'(in_ch) < CHANNELS);
  assign in_addr    = CH_AW'(in_ch);
  assign wr_addr    = CH_AW'(ch_r);
  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign cur_entry  = rd_valid_r ? rd_data_r : ENTRY_RESET;
  assign out_free   = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

  adfu_decode u_decode (
    .cur   (cur_entry),
    .item  (item_r),
    .nxt   (dec_entry),
    .flags (dec_flags)
  );

  assign diff      = (FILT_W + 1)'(work_r.newer) - (FILT_W + 1)'(work_r.older);
  assign frac      = $signed({1'b0, work_r.phase[FRACTION_BITS-1 -: 8]});
  assign prod      = diff * frac;
  assign smp       = 21'(work_r.older) + 21'(prod >>> 8);
  assign phase_sum = work_r.phase + PHASE_W'(rate_r);
  assign emit_last = (phase_sum >= PHASE_ONE) || (cnt_r == CNT_LAST);
  assign emit_go   = (state_r == ST_EMIT) && (work_r.phase < PHASE_ONE) && out_free;

  always_comb begin
    if (cfg_data < RATE_MIN) begin
      rate_sat = RATE_MIN;
    end else if (cfg_data > RATE_MAX) begin
      rate_sat = RATE_MAX;
    end else begin
      rate_sat = cfg_data;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = work_r;
    if (state_r == ST_EMIT) begin
      if (work_r.phase >= PHASE_ONE) begin
        mem_we = 1'b1;
      end else if (out_free && emit_last) begin
        mem_we          = 1'b1;
        mem_wdata.phase = phase_sum;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    ch_nxt         = ch_r;
    work_nxt       = work_r;
    cnt_nxt        = cnt_r;
    rate_nxt       = rate_r;
    valid_nxt      = valid_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    out_err_nxt    = out_err_r;

    if (mem_we) valid_nxt[wr_addr] = 1'b1;
    if (cfg_write) begin
      rate_nxt  = rate_sat;
      valid_nxt = '0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && ch_ok) begin
          state_nxt = ST_DECODE;
          ch_nxt    = in_ch;
          item_nxt  = '{func: in_tuser, start_sample: in_tdata[16:1],
                        start_index: in_tdata[23:17], code: in_tdata[27:24]};
        end
      end
      ST_DECODE: begin
        work_nxt = dec_entry;
        cnt_nxt  = '0;
        if (dec_flags.drop) begin
          state_nxt = ST_IDLE;
        end else if (dec_flags.error) begin
          state_nxt = ST_ERROR;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_ERROR: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = OUT_DATA_W'(ch_r);
          out_last_nxt   = 1'b1;
          out_err_nxt    = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (work_r.phase >= PHASE_ONE) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = OUT_DATA_W'({smp[15:8], ch_r});
          out_last_nxt   = emit_last;
          out_err_nxt    = 1'b0;
          work_nxt.phase = phase_sum;
          cnt_nxt        = cnt_r + CNT_W'(1);
          if (emit_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rate_r       <= RATE_RESET;
      valid_r      <= '0;
      out_tvalid_r <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      rate_r       <= rate_nxt;
      valid_r      <= valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      cnt_r        <= cnt_nxt;
    end
    item_r     <= item_nxt;
    ch_r       <= ch_nxt;
    work_r     <= work_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= mem_wdata;
    if (in_accept) begin
      rd_data_r  <= mem[in_addr];
      rd_valid_r <= valid_r[in_addr];
    end
  end

  `ADFU_ASSERT_NEXT(a_accept_decodes, in_accept && ch_ok, state_r == ST_DECODE,
                    "accepted item did not move to decode")
  `ADFU_ASSERT_SAME(a_write_in_emit, mem_we, state_r == ST_EMIT,
                    "state memory written outside emission")
  `ADFU_ASSERT_SAME(a_error_word, out_tvalid && out_tuser,
                    out_tlast && (out_tdata[8:1] == 8'd0),
                    "error word without last or with a sample")
  `ADFU_ASSERT_NEXT(a_emit_cap, emit_go && (cnt_r == CNT_LAST), state_r == ST_IDLE,
                    "emission ran past its cap")

endmodule
